// ----- hdl/pvag_pkg.sv -----
`default_nettype none
package pvag_pkg;

    localparam int MAX_DIM_DEF      = 4096;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_BITS_DEF   = 16;

    // vector lanes carry the pitch vector (up to 2^30) plus CORDIC growth
    localparam int XW = 34;
    // angle accumulator, wide enough for 0.75 turn at 24 angle bits
    localparam int ZW = 27;

    localparam int AW    = 5;

    typedef enum logic [2:0] {
        REG_VIEW_YAW     = 3'd0,
        REG_VIEW_PITCH   = 3'd1,
        REG_OUT_WIDTH    = 3'd2,
        REG_OUT_HEIGHT   = 3'd3,
        REG_SRC_WIDTH    = 3'd4,
        REG_SRC_HEIGHT   = 3'd5,
        REG_VERT_EXTENT  = 3'd6,
        REG_SRC_STRIDE   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [15:0] view_yaw;
        logic signed [14:0] view_pitch;
        logic [12:0]        out_width;
        logic [12:0]        out_height;
        logic [12:0]        src_width;
        logic [12:0]        src_height;
        logic [15:0]        vertical_extent;
        logic [13:0]        src_stride;
    } cfg_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } lane_t;

    typedef struct packed {
        logic  vld;
        lane_t yaw;
        lane_t pitch;
    } cell_t;

    // atan(2^-i) per turn, 2^-32 units
    localparam logic [31:0] ATAN_TAB [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // table entry rounded half up to the angle resolution
    function automatic logic signed [ZW-1:0] cordic_angle(input int step, input int ab);
        logic [32:0] t;
        t = {1'b0, ATAN_TAB[step]} + (33'd1 << (31 - ab));
        return ZW'(t >> (32 - ab));
    endfunction

    // one vectoring micro-rotation, floor shifts
    function automatic lane_t cordic_rot(input lane_t l, input int sh,
                                         input logic signed [ZW-1:0] a);
        lane_t r;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        dx = l.y >>> sh;
        dy = l.x >>> sh;
        if (!l.y[XW-1]) begin
            r.x = l.x + dx;
            r.y = l.y - dy;
            r.z = l.z + a;
        end else begin
            r.x = l.x - dx;
            r.y = l.y + dy;
            r.z = l.z - a;
        end
        return r;
    endfunction

    // scale the vector up by powers of two until the larger magnitude reaches 2^29
    function automatic lane_t normalize(input lane_t l);
        lane_t r;
        logic [XW-1:0] m;
        r = l;
        m = (r.x[XW-1] ? XW'(-r.x) : XW'(r.x)) | (r.y[XW-1] ? XW'(-r.y) : XW'(r.y));
        for (int k = 16; k >= 1; k = k / 2) begin
            if (m < (XW'(1) << (29 - k))) begin
                r.x = r.x <<< k;
                r.y = r.y <<< k;
                m   = m << k;
            end
        end
        if (m < (XW'(1) << 29)) begin
            r.x = r.x <<< 1;
            r.y = r.y <<< 1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/pvag_regs.sv -----
`default_nettype none
module pvag_regs (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [pvag_pkg::AW-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready,
    output pvag_pkg::cfg_t             cfg
);
    import pvag_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[AW-1:2]);
    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_VIEW_YAW:     cfg_next.view_yaw        = pwdata[15:0];
                REG_VIEW_PITCH:   cfg_next.view_pitch      = pwdata[14:0];
                REG_OUT_WIDTH:    cfg_next.out_width       = pwdata[12:0];
                REG_OUT_HEIGHT:   cfg_next.out_height      = pwdata[12:0];
                REG_SRC_WIDTH:    cfg_next.src_width       = pwdata[12:0];
                REG_SRC_HEIGHT:   cfg_next.src_height      = pwdata[12:0];
                REG_VERT_EXTENT:  cfg_next.vertical_extent = pwdata[15:0];
                REG_SRC_STRIDE:   cfg_next.src_stride      = pwdata[13:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_VIEW_YAW:     prdata = {16'd0, cfg_reg.view_yaw};
            REG_VIEW_PITCH:   prdata = {17'd0, cfg_reg.view_pitch};
            REG_OUT_WIDTH:    prdata = {19'd0, cfg_reg.out_width};
            REG_OUT_HEIGHT:   prdata = {19'd0, cfg_reg.out_height};
            REG_SRC_WIDTH:    prdata = {19'd0, cfg_reg.src_width};
            REG_SRC_HEIGHT:   prdata = {19'd0, cfg_reg.src_height};
            REG_VERT_EXTENT:  prdata = {16'd0, cfg_reg.vertical_extent};
            REG_SRC_STRIDE:   prdata = {18'd0, cfg_reg.src_stride};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.view_yaw        <= '0;
            cfg_reg.view_pitch      <= '0;
            cfg_reg.out_width       <= 13'd320;
            cfg_reg.out_height      <= 13'd200;
            cfg_reg.src_width       <= 13'd1280;
            cfg_reg.src_height      <= 13'd720;
            cfg_reg.vertical_extent <= 16'd17495;
            cfg_reg.src_stride      <= 14'd3840;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/pvag_cell.sv -----
`default_nettype none
module pvag_cell #(
    parameter int STEP       = 0,
    parameter int ANGLE_BITS = pvag_pkg::ANGLE_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire pvag_pkg::cell_t din,
    output pvag_pkg::cell_t    dout
);
    import pvag_pkg::*;

    localparam logic signed [ZW-1:0] ANG = cordic_angle(STEP, ANGLE_BITS);

    cell_t dout_reg;
    cell_t dout_next;

    always_comb
    begin
        dout_next.vld   = din.vld;
        dout_next.yaw   = cordic_rot(din.yaw, STEP, ANG);
        dout_next.pitch = cordic_rot(din.pitch, STEP, ANG);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg <= '0;
        else
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;
endmodule
`default_nettype wire

// ----- hdl/panorama_view_address_gen.sv -----
`default_nettype none
// Channel   Direction  Transfer when           Payload
// command   in         start && !busy          view_x, view_y
// result    out        done (one cycle)        src_col, src_row, src_offset
// config    in/out     psel&penable&pwrite     paddr, pwdata / prdata
//
// A command passes the stage 0 and stage 1 registers, the CORDIC cells and the
// P1, P2 and P3 registers; done rises with the P3 result registers.
// One pixel per cycle: busy is never raised; the chain of CORDIC cells sets
// the depth, each cell doing one micro-rotation for both angles.
// rst_n is asynchronous; it clears the valid chain and loads the register file defaults.
// Results cannot be held off; done pulses once per accepted command.
module panorama_view_address_gen #(
    parameter int MAX_DIM      = pvag_pkg::MAX_DIM_DEF,
    parameter int CORDIC_STEPS = pvag_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_BITS   = pvag_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    output logic                         busy,
    input  wire logic [11:0]             view_x,
    input  wire logic [11:0]             view_y,
    output logic                         done,
    output logic [11:0]                  src_col,
    output logic [11:0]                  src_row,
    output logic [25:0]                  src_offset,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [pvag_pkg::AW-1:0] paddr,
    input  wire logic [31:0]             pwdata,
    output logic      [31:0]             prdata,
    output logic                         pready
);
    import pvag_pkg::*;

    localparam int DW   = $clog2(MAX_DIM + 1);
    localparam int UP   = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
    localparam int DN   = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;
    localparam int TW   = ZW + 2;           // 2*yaw + turn, 4*pitch + turn
    localparam int PW   = TW + DW + 1;      // angle times source dimension
    localparam int OW   = DW + 15;          // byte offset before truncation

    cfg_t cfg;

    pvag_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Dimension clamp to [1, MAX_DIM]
    function automatic logic [DW-1:0] clamp_dim(input logic [12:0] v);
        if (v == 13'd0)
            return DW'(1);
        else if (32'(v) > MAX_DIM)
            return DW'(MAX_DIM);
        else
            return DW'(v);
    endfunction

    logic [DW-1:0] w, h, sw, sh;
    assign w  = clamp_dim(cfg.out_width);
    assign h  = clamp_dim(cfg.out_height);
    assign sw = clamp_dim(cfg.src_width);
    assign sh = clamp_dim(cfg.src_height);

    assign busy = 1'b0;

    // ---- stage 0: build both vectors, seed angles with the offsets ----
    cell_t s0_reg, s0_next;
    logic signed [XW-1:0] pdy;

    always_comb
    begin
        pdy = XW'($signed({1'b0, view_y, 1'b0})) - XW'($signed({1'b0, h}));
        s0_next.vld     = start;
        s0_next.yaw.x   = XW'($signed({1'b0, w}));
        s0_next.yaw.y   = XW'($signed({1'b0, view_x, 1'b0})) - XW'($signed({1'b0, w}));
        s0_next.yaw.z   = (ZW'(cfg.view_yaw) <<< UP) >>> DN;
        s0_next.pitch.x = XW'($signed({1'b0, h})) <<< 15;
        s0_next.pitch.y = XW'(pdy * $signed({1'b0, cfg.vertical_extent}));
        s0_next.pitch.z = (ZW'(cfg.view_pitch) <<< UP) >>> DN;
    end

    // ---- stage 1: normalize vector magnitude ----
    cell_t s1_reg;
    cell_t chain [0:CORDIC_STEPS];
    cell_t s1_next;

    always_comb
    begin
        s1_next.vld   = s0_reg.vld;
        s1_next.yaw   = normalize(s0_reg.yaw);
        s1_next.pitch = normalize(s0_reg.pitch);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_reg <= '0;
            s1_reg <= '0;
        end
        else
        begin
            s0_reg <= s0_next;
            s1_reg <= s1_next;
        end
    end

    assign chain[0] = s1_reg;

    // ---- CORDIC cell chain ----
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        pvag_cell #(
            .STEP       (i),
            .ANGLE_BITS (ANGLE_BITS)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (chain[i]),
            .dout  (chain[i+1])
        );
    end

    // ---- P1: scale angles by source dimensions ----
    cell_t fin;
    assign fin = chain[CORDIC_STEPS];

    logic                 p1_vld_reg;
    logic signed [PW-1:0] cprod_reg, cprod_next;
    logic signed [PW-1:0] rprod_reg, rprod_next;
    logic signed [TW-1:0] ct, rt;

    always_comb
    begin
        ct = (TW'(fin.yaw.z) <<< 1) + (TW'(1) <<< ANGLE_BITS);
        rt = (TW'(fin.pitch.z) <<< 2) + (TW'(1) <<< ANGLE_BITS);
        cprod_next = PW'(ct) * PW'($signed({1'b0, sw}));
        rprod_next = PW'(rt) * PW'($signed({1'b0, sh}));
    end

    // ---- P2: floor, wrap column, clamp row ----
    logic                 p2_vld_reg;
    logic [DW-1:0]        col_reg, col_next;
    logic [DW-1:0]        row_reg, row_next;
    logic signed [PW-1:0] cf, rf, swx, shx;

    always_comb
    begin
        cf  = cprod_reg >>> (ANGLE_BITS + 1);
        rf  = rprod_reg >>> (ANGLE_BITS + 1);
        swx = PW'($signed({1'b0, sw}));
        shx = PW'($signed({1'b0, sh}));
        // column lies within a quarter width outside the source
        if (cf < 0)
            col_next = DW'(cf + swx);
        else if (cf >= swx)
            col_next = DW'(cf - swx);
        else
            col_next = DW'(cf);
        if (rf < 0)
            row_next = '0;
        else if (rf > shx - 1)
            row_next = DW'(shx - 1);
        else
            row_next = DW'(rf);
    end

    // ---- P3: byte offset, result registers ----
    logic          done_reg;
    logic [11:0]   col_out_reg, row_out_reg;
    logic [25:0]   offs_reg;
    logic [OW-1:0] offs_next;

    assign offs_next = OW'(row_reg) * OW'(cfg.src_stride) + OW'(col_reg) * OW'(3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= fin.vld;
            p2_vld_reg <= p1_vld_reg;
            done_reg   <= p2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cprod_reg   <= cprod_next;
        rprod_reg   <= rprod_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        col_out_reg <= 12'(col_reg);
        row_out_reg <= 12'(row_reg);
        offs_reg    <= offs_next[25:0];
    end

    assign done       = done_reg;
    assign src_col    = col_out_reg;
    assign src_row    = row_out_reg;
    assign src_offset = offs_reg;
endmodule
`default_nettype wire

// ----- hdl/pvag_checker.sv -----
`default_nettype none
module pvag_checker #(
    parameter int CORDIC_STEPS = pvag_pkg::CORDIC_STEPS_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire logic pready
);
    localparam int LAT = CORDIC_STEPS + 5;

    // every accepted command yields a result after the fixed latency
    a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("result missing after accepted command");

    // no result without a matching command
    a_lat_bwd: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without command");

    // full rate: never stalls the command side
    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");
endmodule

bind panorama_view_address_gen pvag_checker #(
    .CORDIC_STEPS (CORDIC_STEPS)
) u_pvag_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .pready (pready)
);
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for panorama_view_address_gen.
// A behavioral predictor computes the source column, row and byte offset of
// each accepted view pixel; transfers out are matched in order against it.
// Phases: reset values, then several register settings (extremes included),
// each with a directed table followed by random pixels.
module testbench;
    import pvag_pkg::*;

    localparam int LATENCY   = CORDIC_STEPS_DEF + 5;
    localparam int WDOG_MAX  = 2000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [11:0] view_x;
    logic [11:0] view_y;
    logic        done;
    logic [11:0] src_col;
    logic [11:0] src_row;
    logic [25:0] src_offset;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    panorama_view_address_gen dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .view_x(view_x), .view_y(view_y), .done(done),
        .src_col(src_col), .src_row(src_row), .src_offset(src_offset),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef struct {
        logic [11:0] col;
        logic [11:0] row;
        logic [25:0] offs;
    } src_addr_t;

    // shadow copy of the register file
    longint sh_yaw, sh_pitch;
    longint sh_ow, sh_oh, sh_sw, sh_sh, sh_ext, sh_stride;

    src_addr_t addr_q[$];
    int  errors;
    int  n_sent;
    int  n_checked;
    int  idle_cycles;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint fshr(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-v + ((64'sd1 <<< s) - 1)) >>> s);
    endfunction

    function automatic longint clampd(longint v);
        if (v < 1)
            return 1;
        if (v > MAX_DIM_DEF)
            return MAX_DIM_DEF;
        return v;
    endfunction

    // vectoring arctangent, 65536 units per turn
    function automatic longint vec_angle(longint x, longint y);
        longint z, a, dx, dy;
        logic [32:0] t;
        z = 0;
        while ((x < 0 ? -x : x) < (64'sd1 <<< 29) && (y < 0 ? -y : y) < (64'sd1 <<< 29)) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            t  = {1'b0, ATAN_TAB[i]} + (33'd1 << (31 - ANGLE_BITS_DEF));
            a  = longint'(t >> (32 - ANGLE_BITS_DEF));
            dx = fshr(y, i);
            dy = fshr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += a;
            end else begin
                x -= dx; y += dy; z -= a;
            end
        end
        return z;
    endfunction

    function automatic src_addr_t project_pixel(longint vx, longint vy);
        src_addr_t r;
        longint w, h, sw, shh, yaw, pitch, col, row, offs;
        w   = clampd(sh_ow);
        h   = clampd(sh_oh);
        sw  = clampd(sh_sw);
        shh = clampd(sh_sh);
        yaw   = fshr(sh_yaw * 65536, 16) + vec_angle(w, 2 * vx - w);
        pitch = fshr(sh_pitch * 65536, 16)
              + vec_angle(h * 32768, (2 * vy - h) * sh_ext);
        col = fshr((2 * yaw + 65536) * sw, 17) % sw;
        if (col < 0)
            col += sw;
        row = fshr((4 * pitch + 65536) * shh, 17);
        if (row < 0)
            row = 0;
        if (row > shh - 1)
            row = shh - 1;
        offs = row * sh_stride + col * 3;
        r.col  = col[11:0];
        r.row  = row[11:0];
        r.offs = offs[25:0];
        return r;
    endfunction

    // result checker and watchdog
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (addr_q.size() == 0) begin
                $display("%0t: unexpected transfer col=%0d row=%0d offs=%0d",
                         $time, src_col, src_row, src_offset);
                errors++;
            end else begin
                src_addr_t e;
                e = addr_q.pop_front();
                if (src_col !== e.col) begin
                    $display("%0t: src_col expected %0d actual %0d", $time, e.col, src_col);
                    errors++;
                end
                if (src_row !== e.row) begin
                    $display("%0t: src_row expected %0d actual %0d", $time, e.row, src_row);
                    errors++;
                end
                if (src_offset !== e.offs) begin
                    $display("%0t: src_offset expected %0d actual %0d",
                             $time, e.offs, src_offset);
                    errors++;
                end
                n_checked++;
            end
        end
        if (rst_n && !(done || (start && !busy) || (psel && penable)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= WDOG_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = AW'(4 * int'(idx)); pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_VIEW_YAW:     sh_yaw    = longint'($signed(val[15:0]));
            REG_VIEW_PITCH:   sh_pitch  = longint'($signed(val[14:0]));
            REG_OUT_WIDTH:    sh_ow     = val[12:0];
            REG_OUT_HEIGHT:   sh_oh     = val[12:0];
            REG_SRC_WIDTH:    sh_sw     = val[12:0];
            REG_SRC_HEIGHT:   sh_sh     = val[12:0];
            REG_VERT_EXTENT:  sh_ext    = val[15:0];
            default:          sh_stride = val[13:0];
        endcase
    endtask

    // one command transfer, with a random gap before it
    task automatic send_pixel(logic [11:0] x, logic [11:0] y, bit check_fixed,
                              src_addr_t fixed);
        int gap;
        gap = $urandom_range(0, 5);
        repeat (gap) @(negedge clk);
        start = 1'b1; view_x = x; view_y = y;
        do @(posedge clk); while (busy);
        addr_q.push_back(check_fixed ? fixed : project_pixel(x, y));
        n_sent++;
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (addr_q.size() != 0 && guard < 10 * LATENCY + 100) begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        bit          fixed;
        src_addr_t   res;
    } pixel_row_t;

    pixel_row_t dir_tab[] = '{
        // view center at reset: yaw 0, pitch 0 -> middle of the source
        '{12'd160,  12'd100,  1'b1, '{12'd640, 12'd360, 26'd1384320}},
        '{12'd0,    12'd0,    1'b0, '{0, 0, 0}},
        '{12'd319,  12'd199,  1'b0, '{0, 0, 0}},
        '{12'd4095, 12'd4095, 1'b0, '{0, 0, 0}},
        '{12'd4095, 12'd0,    1'b0, '{0, 0, 0}},
        '{12'd0,    12'd4095, 1'b0, '{0, 0, 0}},
        '{12'd2730, 12'd1365, 1'b0, '{0, 0, 0}},
        '{12'd1365, 12'd2730, 1'b0, '{0, 0, 0}},
        '{12'd320,  12'd200,  1'b0, '{0, 0, 0}},
        '{12'd161,  12'd99,   1'b0, '{0, 0, 0}}
    };

    task automatic run_phase(int n_rand, int xmax, int ymax);
        src_addr_t none;
        none = '{0, 0, 0};
        foreach (dir_tab[i])
            send_pixel(dir_tab[i].x, dir_tab[i].y,
                       dir_tab[i].fixed && sh_yaw == 0 && sh_pitch == 0 &&
                       sh_ow == 320 && sh_oh == 200 && sh_sw == 1280 &&
                       sh_sh == 720 && sh_ext == 17495 && sh_stride == 3840,
                       dir_tab[i].res);
        for (int i = 0; i < n_rand; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_pixel(12'($urandom), 12'($urandom), 1'b0, none);
            else
                send_pixel(12'($urandom_range(0, xmax)), 12'($urandom_range(0, ymax)),
                           1'b0, none);
        end
        drain();
    endtask

    initial begin
        errors = 0; n_sent = 0; n_checked = 0; idle_cycles = 0;
        rst_n = 1'b0; start = 1'b0; view_x = '0; view_y = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        sh_yaw = 0; sh_pitch = 0; sh_ow = 320; sh_oh = 200;
        sh_sw = 1280; sh_sh = 720; sh_ext = 17495; sh_stride = 3840;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // reset settings
        run_phase(60, 319, 199);

        // extremes: max yaw, pitch 8192, largest dimensions and a stride of 12288
        reg_write(REG_VIEW_YAW,     32'h0000_7FFF);
        reg_write(REG_VIEW_PITCH,   32'd8192);
        reg_write(REG_OUT_WIDTH,    32'd4096);
        reg_write(REG_OUT_HEIGHT,   32'd4096);
        reg_write(REG_SRC_WIDTH,    32'd4096);
        reg_write(REG_SRC_HEIGHT,   32'd4096);
        reg_write(REG_VERT_EXTENT,  32'd65535);
        reg_write(REG_SRC_STRIDE,   32'd12288);
        run_phase(70, 4095, 4095);

        // most negative yaw, pitch -8192, zero dimensions clamp to one, zero extent
        reg_write(REG_VIEW_YAW,     32'h0000_8000);
        reg_write(REG_VIEW_PITCH,   32'h0000_6000);
        reg_write(REG_OUT_WIDTH,    32'd0);
        reg_write(REG_OUT_HEIGHT,   32'd0);
        reg_write(REG_SRC_WIDTH,    32'd0);
        reg_write(REG_SRC_HEIGHT,   32'd0);
        reg_write(REG_VERT_EXTENT,  32'd0);
        reg_write(REG_SRC_STRIDE,   32'd3);
        run_phase(50, 15, 15);

        // oversized dimensions clamp to the maximum, with the largest stride
        reg_write(REG_OUT_WIDTH,    32'h1FFF);
        reg_write(REG_OUT_HEIGHT,   32'h1FFF);
        reg_write(REG_SRC_WIDTH,    32'h1FFF);
        reg_write(REG_SRC_HEIGHT,   32'h1FFF);
        reg_write(REG_SRC_STRIDE,   32'h3FFF);
        reg_write(REG_VERT_EXTENT,  32'd30000);
        run_phase(50, 4095, 4095);

        // random register settings
        for (int p = 0; p < 3; p++) begin
            reg_write(REG_VIEW_YAW,     $urandom);
            reg_write(REG_VIEW_PITCH,   32'($urandom_range(0, 16384)) - 32'd8192);
            reg_write(REG_OUT_WIDTH,    $urandom_range(1, 4096));
            reg_write(REG_OUT_HEIGHT,   $urandom_range(1, 4096));
            reg_write(REG_SRC_WIDTH,    $urandom_range(1, 4096));
            reg_write(REG_SRC_HEIGHT,   $urandom_range(1, 4096));
            reg_write(REG_VERT_EXTENT,  $urandom_range(0, 65535));
            reg_write(REG_SRC_STRIDE,   $urandom_range(3, 12288));
            run_phase(40, int'(sh_ow), int'(sh_oh));
        end

        $display("Covered %0d pixel transfers over 7 register settings, %0d checked.",
                 n_sent, n_checked);
        if (errors == 0 && addr_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
